FILE: hdl/drr_pkg.sv
// ---------------------------------------------------------------------------
// drr_pkg
// Shared types and constants for the delimited response receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

   localparam int TIMER_W = 24;
   localparam int BYTE_W  = 8;

   typedef enum logic [1:0] {
      CMD_REQUEST = 2'd0,
      CMD_BYTE    = 2'd1,
      CMD_TICK    = 2'd2
   } drr_cmd_code_type;

   typedef enum logic [1:0] {
      REG_START_DELIM = 2'd0,
      REG_END_DELIM   = 2'd1,
      REG_TIMEOUT     = 2'd2
   } drr_reg_index_type;

   localparam logic [BYTE_W-1:0]  START_DELIM_RESET = 8'd2;
   localparam logic [BYTE_W-1:0]  END_DELIM_RESET   = 8'd3;
   localparam logic [TIMER_W-1:0] TIMEOUT_RESET     = 24'd120000;

   typedef struct packed {
      logic clr_timer;
      logic tick;
      logic clr_fill;
      logic store;
      logic rd_start;
      logic rd_next;
   } drr_ctrl_type;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic byte_expire;
      logic tick_expire;
      logic fill_zero;
      logic fill_full;
      logic rd_last;
   } drr_status_type;

endpackage

`default_nettype wire

FILE: hdl/drr_datapath.sv
// ---------------------------------------------------------------------------
// drr_datapath
// Config registers, timeout timer, fill count, message store and read-out.
// ---------------------------------------------------------------------------
`default_nettype none

module drr_datapath
   import drr_pkg::*;
#(
   parameter int BUFFER_BYTES = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic [1:0]           csr_index,
   input  wire logic [TIMER_W-1:0]   csr_data,
   input  wire logic [BYTE_W-1:0]    data_byte,
   input  wire drr_ctrl_type         ctrl,
   output drr_status_type            status,
   output logic [BYTE_W-1:0]         msg_byte,
   output logic                      msg_last
);

   localparam int AW = (BUFFER_BYTES > 2) ? $clog2(BUFFER_BYTES) : 1;
   localparam logic [AW-1:0] FILL_MAX = AW'(BUFFER_BYTES - 1);

   logic [BYTE_W-1:0]  start_ff;
   logic [BYTE_W-1:0]  end_ff;
   logic [TIMER_W-1:0] timeout_ff;
   logic [TIMER_W-1:0] elapsed_ff;
   logic [TIMER_W-1:0] elapsed_in;
   logic [AW-1:0]      fill_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [BYTE_W-1:0]  store_mem [BUFFER_BYTES];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_DELIM_RESET;
         end_ff     <= END_DELIM_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_START_DELIM: start_ff   <= csr_data[BYTE_W-1:0];
            REG_END_DELIM:   end_ff     <= csr_data[BYTE_W-1:0];
            REG_TIMEOUT:     timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // saturating increment
   assign elapsed_in = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         fill_ff    <= '0;
         rd_idx_ff  <= '0;
      end else begin
         if (ctrl.clr_timer) begin
            elapsed_ff <= '0;
         end else if (ctrl.tick) begin
            elapsed_ff <= elapsed_in;
         end
         if (ctrl.clr_fill) begin
            fill_ff <= '0;
         end else if (ctrl.store) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (ctrl.rd_start) begin
            rd_idx_ff <= '0;
         end else if (ctrl.rd_next) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.store) begin
         store_mem[fill_ff] <= data_byte;
      end
      rd_data_ff <= store_mem[rd_idx_ff];
   end

   always_comb begin
      status.is_start    = (data_byte == start_ff);
      status.is_end      = (data_byte == end_ff);
      status.byte_expire = (elapsed_ff > timeout_ff);
      status.tick_expire = (elapsed_in > timeout_ff);
      status.fill_zero   = (fill_ff == '0);
      status.fill_full   = (fill_ff == FILL_MAX);
      status.rd_last     = ({1'b0, rd_idx_ff} + 1'b1) == {1'b0, fill_ff};
   end

   assign msg_byte = rd_data_ff;
   assign msg_last = status.rd_last;

endmodule

`default_nettype wire

FILE: hdl/drr_ctrl.sv
// ---------------------------------------------------------------------------
// drr_ctrl
// Arm / message / drain sequencer for the delimited response receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module drr_ctrl
   import drr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_fire,
   input  wire logic [1:0]      req_cmd,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire drr_status_type  status,
   output drr_ctrl_type         ctrl
);

   typedef enum logic [2:0] {
      ST_DISARMED,
      ST_ARMED,
      ST_IN_MSG,
      ST_RD,
      ST_SEND
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_DISARMED: begin
            if (req_fire && req_cmd == CMD_REQUEST) begin
               state_in       = ST_ARMED;
               ctrl.clr_timer = 1'b1;
               ctrl.clr_fill  = 1'b1;
            end
         end
         ST_ARMED, ST_IN_MSG: begin
            if (req_fire) begin
               unique case (req_cmd)
                  CMD_TICK: begin
                     ctrl.tick = 1'b1;
                     if (status.tick_expire) begin
                        state_in = ST_DISARMED;
                     end
                  end
                  CMD_BYTE: begin
                     if (status.byte_expire) begin
                        state_in = ST_DISARMED;
                     end else if (status.is_start) begin
                        state_in      = ST_IN_MSG;
                        ctrl.clr_fill = 1'b1;
                     end else if (status.is_end) begin
                        if (state_ff == ST_IN_MSG && !status.fill_zero) begin
                           state_in      = ST_RD;
                           ctrl.rd_start = 1'b1;
                        end else begin
                           state_in = ST_ARMED;
                        end
                     end else if (state_ff == ST_IN_MSG && !status.fill_full) begin
                        ctrl.store = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (status.rd_last) begin
                  state_in = ST_DISARMED;
               end else begin
                  state_in     = ST_RD;
                  ctrl.rd_next = 1'b1;
               end
            end
         end
         default: state_in = ST_DISARMED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DISARMED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == ST_SEND);
      end
   end

   assign req_ready = (state_ff == ST_DISARMED) || (state_ff == ST_ARMED) ||
                      (state_ff == ST_IN_MSG);
   assign rsp_valid = rsp_valid_ff;

   a_no_accept_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("input ready while a result beat is pending");

   a_store_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.store |-> !status.fill_full)
      else $error("store write with buffer full");

   a_drain_not_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.rd_start |-> !status.fill_zero)
      else $error("drain started with nothing stored");

   a_last_disarms: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && status.rd_last) |=> (state_ff == ST_DISARMED))
      else $error("block still armed after final beat");

endmodule

`default_nettype wire

FILE: hdl/delimited_response_receiver_top.sv
// ---------------------------------------------------------------------------
// delimited_response_receiver_top
// Waits for one delimited response after a request and streams it out.
//
// req channel: tuser carries the command (request, received byte, tick),
// tdata the received byte. A request arms the block; while armed, bytes
// between the start and end delimiters are stored, ticks run the timeout.
// rsp channel: one beat per stored byte, tlast on the final one.
// csr channel: always ready; index 0 start delimiter, 1 end delimiter,
// 2 timeout in ticks. Write only while idle.
// Throughput: one req beat per cycle while not draining. A drain reads each
// byte from the store into the output register, then offers it on rsp;
// req_tready stays low from the closing end byte until the last beat is
// taken. A stalled receiver simply holds the current beat.
// Reset: disarmed, delimiters 2 and 3, timeout 120000; the store is not
// cleared and no sweep is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module delimited_response_receiver_top
   import drr_pkg::*;
#(
   parameter int BUFFER_BYTES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic [1:0]   req_tuser,   // [1:0] cmd
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] msg_byte
   output logic              rsp_tlast,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_data
);

   drr_ctrl_type   ctrl;
   drr_status_type status;
   logic           req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_tvalid && req_tready;

   drr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .ctrl      (ctrl)
   );

   drr_datapath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .data_byte (req_tdata),
      .ctrl      (ctrl),
      .status    (status),
      .msg_byte  (rsp_tdata),
      .msg_last  (rsp_tlast)
   );

endmodule

`default_nettype wire
